// ===== rtl/block_matrix_multiply_assert.svh =====
// assertion macros used by the block_matrix_multiply checker
`ifndef BLOCK_MATRIX_MULTIPLY_ASSERT_SVH
`define BLOCK_MATRIX_MULTIPLY_ASSERT_SVH

// consequent checked in the cycle after the antecedent
`define BMM_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("block_matrix_multiply: next-cycle property failed");

// consequent checked in the same cycle as the antecedent
`define BMM_ASSERT_SAME(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("block_matrix_multiply: same-cycle property failed");

`endif

// ===== rtl/bmm_pkg.sv =====
// types, codes and constants of the block matrix multiplier
`default_nettype none

package bmm_pkg;

    // default sizes
    localparam int ROWS_MAX_DEF  = 8;
    localparam int INNER_MAX_DEF = 64;
    localparam int COLS_MAX_DEF  = 8;
    localparam int ELEM_BITS_DEF = 16;

    // fixed field widths
    localparam int KIND_W      = 2;
    localparam int IDX_W       = 6;
    localparam int OUT_IDX_W   = 3;
    localparam int VALUE_W     = 38;
    localparam int ROWS_CFG_W  = 4;
    localparam int INNER_CFG_W = 7;
    localparam int COLS_CFG_W  = 4;
    localparam int CFG_ADDR_W  = 2;
    localparam int CFG_DATA_W  = 7;

    // input word kinds
    localparam logic [KIND_W-1:0] KIND_LOAD_A = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LOAD_B = 2'd1;
    localparam logic [KIND_W-1:0] KIND_START  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_ROWS  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_INNER = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_COLS  = 2'd2;

    // configuration reset values
    localparam logic [ROWS_CFG_W-1:0]  ROWS_RESET  = 4'd8;
    localparam logic [INNER_CFG_W-1:0] INNER_RESET = 7'd64;
    localparam logic [COLS_CFG_W-1:0]  COLS_RESET  = 4'd8;

    // commands from controller to datapath
    typedef struct packed {
        logic wr_a;
        logic wr_b;
        logic clear;
        logic issue;
        logic emit;
        logic last;
    } ctrl_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic pipe_busy;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/bmm_ram.sv =====
// generic simple dual-port ram with registered read
`default_nettype none

module bmm_ram #(
    parameter int WIDTH  = 16,
    parameter int DEPTH  = 512,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ===== rtl/bmm_ctrl.sv =====
// controller: configuration registers, loop counters and sequencing fsm
`default_nettype none

module bmm_ctrl #(
    parameter int ROWS_MAX  = bmm_pkg::ROWS_MAX_DEF,
    parameter int INNER_MAX = bmm_pkg::INNER_MAX_DEF,
    parameter int COLS_MAX  = bmm_pkg::COLS_MAX_DEF,
    parameter int ROW_W     = (ROWS_MAX > 1) ? $clog2(ROWS_MAX) : 1,
    parameter int COL_W     = (COLS_MAX > 1) ? $clog2(COLS_MAX) : 1,
    parameter int J_W       = (INNER_MAX > 1) ? $clog2(INNER_MAX) : 1
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    input  wire logic [bmm_pkg::KIND_W-1:0]       s_kind,
    output logic                                  s_ready,
    input  wire logic                             cfg_we,
    input  wire logic [bmm_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  wire logic [bmm_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output bmm_pkg::ctrl_cmd_t                    cmd,
    input  wire bmm_pkg::dp_status_t              status,
    output logic      [ROW_W-1:0]                 row_idx,
    output logic      [COL_W-1:0]                 col_idx,
    output logic      [J_W-1:0]                   inner_idx
);

    import bmm_pkg::*;

    localparam int NR_W = $clog2(ROWS_MAX + 1);
    localparam int NI_W = $clog2(INNER_MAX + 1);
    localparam int NC_W = $clog2(COLS_MAX + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ELEM,
        ST_MAC,
        ST_WAIT
    } state_t;

    state_t                 state_reg, state_next;
    logic [ROWS_CFG_W-1:0]  rows_reg, rows_next;
    logic [INNER_CFG_W-1:0] inner_reg, inner_next;
    logic [COLS_CFG_W-1:0]  cols_reg, cols_next;
    logic [NR_W-1:0]        nr_reg, nr_next;
    logic [NI_W-1:0]        ni_reg, ni_next;
    logic [NC_W-1:0]        nc_reg, nc_next;
    logic [ROW_W-1:0]       r_reg, r_next;
    logic [COL_W-1:0]       c_reg, c_next;
    logic [J_W-1:0]         j_reg, j_next;
    logic                   row_end;
    logic                   col_end;

    assign row_end   = (NR_W'(r_reg) + NR_W'(1)) == nr_reg;
    assign col_end   = (NC_W'(c_reg) + NC_W'(1)) == nc_reg;
    assign row_idx   = r_reg;
    assign col_idx   = c_reg;
    assign inner_idx = j_reg;

    // next state, counters and commands
    always_comb begin
        state_next = state_reg;
        rows_next  = rows_reg;
        inner_next = inner_reg;
        cols_next  = cols_reg;
        nr_next    = nr_reg;
        ni_next    = ni_reg;
        nc_next    = nc_reg;
        r_next     = r_reg;
        c_next     = c_reg;
        j_next     = j_reg;
        cmd        = '0;
        s_ready    = (state_reg == ST_IDLE);

        // register writes, only while idle by contract
        if (cfg_we) begin
            case (cfg_addr)
                CFG_ROWS:  rows_next  = ROWS_CFG_W'(cfg_wdata);
                CFG_INNER: inner_next = INNER_CFG_W'(cfg_wdata);
                CFG_COLS:  cols_next  = COLS_CFG_W'(cfg_wdata);
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    case (s_kind)
                        KIND_LOAD_A: cmd.wr_a = 1'b1;
                        KIND_LOAD_B: cmd.wr_b = 1'b1;
                        KIND_START: begin
                            // saturate dimensions to the store sizes
                            nr_next = (rows_reg > ROWS_MAX) ? NR_W'(ROWS_MAX) : NR_W'(rows_reg);
                            ni_next = (inner_reg > INNER_MAX) ? NI_W'(INNER_MAX)
                                                              : NI_W'(inner_reg);
                            nc_next = (cols_reg > COLS_MAX) ? NC_W'(COLS_MAX) : NC_W'(cols_reg);
                            r_next  = '0;
                            c_next  = '0;
                            if (nr_next != '0 && nc_next != '0) begin
                                state_next = ST_ELEM;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_ELEM: begin
                // start of one c element
                cmd.clear  = 1'b1;
                j_next     = '0;
                state_next = (ni_reg == '0) ? ST_WAIT : ST_MAC;
            end
            ST_MAC: begin
                cmd.issue = 1'b1;
                if ((NI_W'(j_reg) + NI_W'(1)) == ni_reg) begin
                    state_next = ST_WAIT;
                end else begin
                    j_next = j_reg + J_W'(1);
                end
            end
            ST_WAIT: begin
                // drain the mac pipe, then hand the sum to the output register
                if (!status.pipe_busy && status.out_free) begin
                    cmd.emit = 1'b1;
                    cmd.last = row_end && col_end;
                    if (row_end && col_end) begin
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_ELEM;
                        if (col_end) begin
                            c_next = '0;
                            r_next = r_reg + ROW_W'(1);
                        end else begin
                            c_next = c_reg + COL_W'(1);
                        end
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state and registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            rows_reg  <= ROWS_RESET;
            inner_reg <= INNER_RESET;
            cols_reg  <= COLS_RESET;
            nr_reg    <= '0;
            ni_reg    <= '0;
            nc_reg    <= '0;
            r_reg     <= '0;
            c_reg     <= '0;
            j_reg     <= '0;
        end else begin
            state_reg <= state_next;
            rows_reg  <= rows_next;
            inner_reg <= inner_next;
            cols_reg  <= cols_next;
            nr_reg    <= nr_next;
            ni_reg    <= ni_next;
            nc_reg    <= nc_next;
            r_reg     <= r_next;
            c_reg     <= c_next;
            j_reg     <= j_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/bmm_datapath.sv =====
// datapath: element stores, multiply-accumulate pipe and output register
`default_nettype none

module bmm_datapath #(
    parameter int ROWS_MAX  = bmm_pkg::ROWS_MAX_DEF,
    parameter int INNER_MAX = bmm_pkg::INNER_MAX_DEF,
    parameter int COLS_MAX  = bmm_pkg::COLS_MAX_DEF,
    parameter int ELEM_BITS = bmm_pkg::ELEM_BITS_DEF,
    parameter int ROW_W     = (ROWS_MAX > 1) ? $clog2(ROWS_MAX) : 1,
    parameter int COL_W     = (COLS_MAX > 1) ? $clog2(COLS_MAX) : 1,
    parameter int J_W       = (INNER_MAX > 1) ? $clog2(INNER_MAX) : 1
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic        [bmm_pkg::IDX_W-1:0]     s_row_index,
    input  wire logic        [bmm_pkg::IDX_W-1:0]     s_col_index,
    input  wire logic signed [ELEM_BITS-1:0]          s_element,
    input  wire bmm_pkg::ctrl_cmd_t                   cmd,
    input  wire logic        [ROW_W-1:0]              row_idx,
    input  wire logic        [COL_W-1:0]              col_idx,
    input  wire logic        [J_W-1:0]                inner_idx,
    output bmm_pkg::dp_status_t                       status,
    input  wire logic                                 m_ready,
    output logic                                      m_valid,
    output logic             [bmm_pkg::OUT_IDX_W-1:0] m_out_row,
    output logic             [bmm_pkg::OUT_IDX_W-1:0] m_out_col,
    output logic signed      [bmm_pkg::VALUE_W-1:0]   m_product_value,
    output logic                                      m_last
);

    import bmm_pkg::*;

    localparam int A_DEPTH = ROWS_MAX * INNER_MAX;
    localparam int B_DEPTH = INNER_MAX * COLS_MAX;
    localparam int A_AW    = (A_DEPTH > 1) ? $clog2(A_DEPTH) : 1;
    localparam int B_AW    = (B_DEPTH > 1) ? $clog2(B_DEPTH) : 1;
    localparam int PROD_W  = 2 * ELEM_BITS;
    localparam int EXT_W   = (PROD_W > VALUE_W) ? PROD_W : VALUE_W;

    logic                        a_we;
    logic                        b_we;
    logic [A_AW-1:0]             a_waddr;
    logic [B_AW-1:0]             b_waddr;
    logic [A_AW-1:0]             a_raddr;
    logic [B_AW-1:0]             b_raddr;
    logic [ELEM_BITS-1:0]        a_rdata;
    logic [ELEM_BITS-1:0]        b_rdata;
    logic                        rd_valid_reg;
    logic                        prod_valid_reg;
    logic signed [PROD_W-1:0]    prod_next;
    logic signed [PROD_W-1:0]    prod_reg;
    logic signed [EXT_W-1:0]     prod_ext;
    logic [VALUE_W-1:0]          acc_reg, acc_next;
    logic                        out_valid_reg;
    logic [OUT_IDX_W-1:0]        out_row_reg;
    logic [OUT_IDX_W-1:0]        out_col_reg;
    logic [VALUE_W-1:0]          out_value_reg;
    logic                        out_last_reg;

    // load decode with bounds check, row-major store layout
    assign a_we    = cmd.wr_a && (s_row_index < ROWS_MAX) && (s_col_index < INNER_MAX);
    assign b_we    = cmd.wr_b && (s_row_index < INNER_MAX) && (s_col_index < COLS_MAX);
    assign a_waddr = A_AW'(A_AW'(s_row_index) * A_AW'(INNER_MAX) + A_AW'(s_col_index));
    assign b_waddr = B_AW'(B_AW'(s_row_index) * B_AW'(COLS_MAX) + B_AW'(s_col_index));
    assign a_raddr = A_AW'(A_AW'(row_idx) * A_AW'(INNER_MAX) + A_AW'(inner_idx));
    assign b_raddr = B_AW'(B_AW'(inner_idx) * B_AW'(COLS_MAX) + B_AW'(col_idx));

    bmm_ram #(
        .WIDTH (ELEM_BITS),
        .DEPTH (A_DEPTH)
    ) u_a_store (
        .aclk    (aclk),
        .wr_en   (a_we),
        .wr_addr (a_waddr),
        .wr_data (s_element),
        .rd_addr (a_raddr),
        .rd_data (a_rdata)
    );

    bmm_ram #(
        .WIDTH (ELEM_BITS),
        .DEPTH (B_DEPTH)
    ) u_b_store (
        .aclk    (aclk),
        .wr_en   (b_we),
        .wr_addr (b_waddr),
        .wr_data (s_element),
        .rd_addr (b_raddr),
        .rd_data (b_rdata)
    );

    // signed product and wrap-around accumulate
    assign prod_next = $signed(a_rdata) * $signed(b_rdata);
    assign prod_ext  = EXT_W'(prod_reg);
    assign acc_next  = acc_reg + prod_ext[VALUE_W-1:0];

    always_ff @(posedge aclk) begin
        if (rd_valid_reg) begin
            prod_reg <= prod_next;
        end
        if (cmd.clear) begin
            acc_reg <= '0;
        end else if (prod_valid_reg) begin
            acc_reg <= acc_next;
        end
    end

    // pipe valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_valid_reg   <= 1'b0;
            prod_valid_reg <= 1'b0;
        end else begin
            rd_valid_reg   <= cmd.issue;
            prod_valid_reg <= rd_valid_reg;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_row_reg   <= OUT_IDX_W'(row_idx);
            out_col_reg   <= OUT_IDX_W'(col_idx);
            out_value_reg <= acc_reg;
            out_last_reg  <= cmd.last;
        end
    end

    assign status.pipe_busy = rd_valid_reg || prod_valid_reg;
    assign status.out_free  = !out_valid_reg || m_ready;

    assign m_valid         = out_valid_reg;
    assign m_out_row       = out_row_reg;
    assign m_out_col       = out_col_reg;
    assign m_product_value = $signed(out_value_reg);
    assign m_last          = out_last_reg;

endmodule

`default_nettype wire

// ===== rtl/block_matrix_multiply.sv =====
// load words: one per cycle, ready stays high while idle.
// start word: input stalled until all nr*nc c elements are done;
// each c element takes a clear step, one multiply-accumulate issue per inner index and a
// drain through the read, multiply and add registers, or only the clear step and hand-off when ni is zero.
// a result word held by the receiver stalls the run.
// reset clears control state and sets dimensions to 8, 64, 8; stores are undefined until written.
`default_nettype none

module block_matrix_multiply #(
    parameter int ROWS_MAX  = bmm_pkg::ROWS_MAX_DEF,
    parameter int INNER_MAX = bmm_pkg::INNER_MAX_DEF,
    parameter int COLS_MAX  = bmm_pkg::COLS_MAX_DEF,
    parameter int ELEM_BITS = bmm_pkg::ELEM_BITS_DEF
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire logic        [bmm_pkg::KIND_W-1:0]    s_kind,
    input  wire logic        [bmm_pkg::IDX_W-1:0]     s_row_index,
    input  wire logic        [bmm_pkg::IDX_W-1:0]     s_col_index,
    input  wire logic signed [ELEM_BITS-1:0]          s_element,
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic             [bmm_pkg::OUT_IDX_W-1:0] m_out_row,
    output logic             [bmm_pkg::OUT_IDX_W-1:0] m_out_col,
    output logic signed      [bmm_pkg::VALUE_W-1:0]   m_product_value,
    output logic                                      m_last,
    input  wire logic                                 cfg_we,
    input  wire logic        [bmm_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic        [bmm_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    import bmm_pkg::*;

    localparam int ROW_W = (ROWS_MAX > 1) ? $clog2(ROWS_MAX) : 1;
    localparam int COL_W = (COLS_MAX > 1) ? $clog2(COLS_MAX) : 1;
    localparam int J_W   = (INNER_MAX > 1) ? $clog2(INNER_MAX) : 1;

    ctrl_cmd_t        cmd;
    dp_status_t       status;
    logic [ROW_W-1:0] row_idx;
    logic [COL_W-1:0] col_idx;
    logic [J_W-1:0]   inner_idx;

    bmm_ctrl #(
        .ROWS_MAX  (ROWS_MAX),
        .INNER_MAX (INNER_MAX),
        .COLS_MAX  (COLS_MAX),
        .ROW_W     (ROW_W),
        .COL_W     (COL_W),
        .J_W       (J_W)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_kind    (s_kind),
        .s_ready   (s_ready),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .status    (status),
        .row_idx   (row_idx),
        .col_idx   (col_idx),
        .inner_idx (inner_idx)
    );

    bmm_datapath #(
        .ROWS_MAX  (ROWS_MAX),
        .INNER_MAX (INNER_MAX),
        .COLS_MAX  (COLS_MAX),
        .ELEM_BITS (ELEM_BITS),
        .ROW_W     (ROW_W),
        .COL_W     (COL_W),
        .J_W       (J_W)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_row_index     (s_row_index),
        .s_col_index     (s_col_index),
        .s_element       (s_element),
        .cmd             (cmd),
        .row_idx         (row_idx),
        .col_idx         (col_idx),
        .inner_idx       (inner_idx),
        .status          (status),
        .m_ready         (m_ready),
        .m_valid         (m_valid),
        .m_out_row       (m_out_row),
        .m_out_col       (m_out_col),
        .m_product_value (m_product_value),
        .m_last          (m_last)
    );

endmodule

`default_nettype wire

// ===== rtl/bmm_checker.sv =====
// port-level checker for the block matrix multiplier and its bind
`default_nettype none

`include "block_matrix_multiply_assert.svh"

module bmm_checker (
    input wire logic                                 aclk,
    input wire logic                                 aresetn,
    input wire logic                                 s_valid,
    input wire logic                                 s_ready,
    input wire logic                                 m_valid,
    input wire logic                                 m_ready,
    input wire logic        [bmm_pkg::OUT_IDX_W-1:0] m_out_row,
    input wire logic        [bmm_pkg::OUT_IDX_W-1:0] m_out_col,
    input wire logic signed [bmm_pkg::VALUE_W-1:0]   m_product_value,
    input wire logic                                 m_last
);

    // a stalled result word holds its value
    `BMM_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable({m_product_value, m_out_row, m_out_col, m_last}))

    // a fresh non-final c element means the run is still going
    `BMM_ASSERT_SAME(a_busy_mid_run, aclk, aresetn, $rose(m_valid) && !m_last, !s_ready)

    // no result word appears right after an accepted input word
    `BMM_ASSERT_NEXT(a_no_result_after_accept, aclk, aresetn, s_valid && s_ready, !$rose(m_valid))

endmodule

bind block_matrix_multiply bmm_checker u_bmm_checker (.*);

`default_nettype wire
